### hw/rtl/rda_pkg.sv
// Shared types, constants and the arctangent table of the rigid delta accumulator.
`timescale 1ns / 1ps
`default_nettype none

package rda_pkg;

    localparam int CORDIC_ITERS = 24;
    localparam int IDX_W        = $clog2(CORDIC_ITERS);
    localparam int GUARD_SHIFT  = 4;
    localparam int GAIN_Q24     = 10188013;
    localparam int GAIN_W       = 25;
    localparam int OUT_SHIFT    = 28;
    localparam int ZW           = 33;
    localparam int CW           = 40;
    localparam int RW           = 34;
    localparam int PW           = CW + GAIN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_MULX,
        S_MULZ,
        S_RND,
        S_SUM
    } rda_state_t;

    typedef struct packed {
        logic             load;
        logic             rot;
        logic             mul_x;
        logic             mul_z;
        logic             rnd;
        logic             commit;
        logic             start_mode;
        logic [IDX_W-1:0] iter;
    } rda_cmd_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [IDX_W-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = ZW'(536870912);
            5'd1:    v = ZW'(316933406);
            5'd2:    v = ZW'(167458907);
            5'd3:    v = ZW'(85004756);
            5'd4:    v = ZW'(42667331);
            5'd5:    v = ZW'(21354465);
            5'd6:    v = ZW'(10679838);
            5'd7:    v = ZW'(5340245);
            5'd8:    v = ZW'(2670163);
            5'd9:    v = ZW'(1335087);
            5'd10:   v = ZW'(667544);
            5'd11:   v = ZW'(333772);
            5'd12:   v = ZW'(166886);
            5'd13:   v = ZW'(83443);
            5'd14:   v = ZW'(41722);
            5'd15:   v = ZW'(20861);
            5'd16:   v = ZW'(10430);
            5'd17:   v = ZW'(5215);
            5'd18:   v = ZW'(2608);
            5'd19:   v = ZW'(1304);
            5'd20:   v = ZW'(652);
            5'd21:   v = ZW'(326);
            5'd22:   v = ZW'(163);
            5'd23:   v = ZW'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/rigid_delta_accumulator_core.sv
// Top level of the rigid delta accumulator: controller and datapath.
//
//  channel  signals                              direction  handshake
//  input    start_req dx dy dz dyaw              in         in_valid / in_ready
//  output   pos_x pos_y pos_z heading saturated  out        out_valid / out_ready
//
// A compose item goes through one load step, 24 CORDIC micro-rotations on one shared
// shift-add unit, the x and z products on the shared gain multiplier, one rounding
// step and one commit step. A start item goes from the load step straight to the
// commit step. The result sits in an output register, so a new item is taken
// while it waits; a second result waits in the commit state until the first is
// taken. Reset clears the pose to zero; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module rigid_delta_accumulator_core
    import rda_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int POS_BITS   = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               start_req,
    input  logic signed [31:0] dx,
    input  logic signed [31:0] dy,
    input  logic signed [31:0] dz,
    input  logic signed [15:0] dyaw,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [15:0] heading,
    output logic               saturated
);

    rda_cmd_t cmd;

    rda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .start_req (start_req),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    rda_datapath #(
        .ANGLE_BITS (ANGLE_BITS),
        .POS_BITS   (POS_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .dx        (dx),
        .dy        (dy),
        .dz        (dz),
        .dyaw      (dyaw),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .heading   (heading),
        .saturated (saturated)
    );

endmodule

`default_nettype wire

### hw/rtl/rda_ctrl.sv
// Sequencing state machine and output handshake of the rigid delta accumulator.
`timescale 1ns / 1ps
`default_nettype none

module rda_ctrl
    import rda_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     start_req,
    input  logic     out_ready,
    output logic     in_ready,
    output logic     out_valid,
    output rda_cmd_t cmd
);

    rda_state_t       state_reg;
    rda_state_t       state_next;
    logic [IDX_W-1:0] iter_reg;
    logic [IDX_W-1:0] iter_next;
    logic             start_reg;
    logic             start_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;
    logic             last_iter;

    assign slot_free = !out_valid_reg || out_ready;
    assign last_iter = (iter_reg == IDX_W'(CORDIC_ITERS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = start_req ? S_SUM : S_ROT;
                end
            end
            S_ROT:
            begin
                if (last_iter)
                begin
                    state_next = S_MULX;
                end
            end
            S_MULX: state_next = S_MULZ;
            S_MULZ: state_next = S_RND;
            S_RND:  state_next = S_SUM;
            S_SUM:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.start_mode = start_reg;
        cmd.iter       = iter_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_ROT:  cmd.rot    = 1'b1;
            S_MULX: cmd.mul_x  = 1'b1;
            S_MULZ: cmd.mul_z  = 1'b1;
            S_RND:  cmd.rnd    = 1'b1;
            S_SUM:  cmd.commit = slot_free;
            default: cmd = '0;
        endcase
    end

    always_comb
    begin
        iter_next      = (state_reg == S_ROT) ? iter_reg + 1'b1 : '0;
        start_next     = cmd.load ? start_req : start_reg;
        out_valid_next = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rda_datapath.sv
// Pose registers, shared CORDIC rotator, gain multiplier and saturating adders.
`timescale 1ns / 1ps
`default_nettype none

module rda_datapath
    import rda_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int POS_BITS   = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  rda_cmd_t           cmd,
    input  logic signed [31:0] dx,
    input  logic signed [31:0] dy,
    input  logic signed [31:0] dz,
    input  logic signed [15:0] dyaw,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [15:0] heading,
    output logic               saturated
);

    localparam int SW  = ((POS_BITS > RW) ? POS_BITS : RW) + 1;
    localparam int EW  = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;
    localparam int ASH = 32 - ANGLE_BITS;

    localparam logic [ANGLE_BITS-1:0] EIGHTH = {3'b001, {(ANGLE_BITS - 3){1'b0}}};
    localparam logic signed [SW-1:0]  POS_MAX =
        {{(SW - POS_BITS + 1){1'b0}}, {(POS_BITS - 1){1'b1}}};
    localparam logic signed [SW-1:0]  POS_MIN = ~POS_MAX;
    localparam logic signed [GAIN_W-1:0] GAIN = GAIN_W'(GAIN_Q24);
    localparam logic signed [PW-1:0]     ROUND_C = PW'(1) << (OUT_SHIFT - 1);

    logic signed [CW-1:0]         a_reg, a_next;
    logic signed [CW-1:0]         b_reg, b_next;
    logic signed [ZW-1:0]         z_reg, z_next;
    logic signed [PW-1:0]         prod_reg, prod_next;
    logic signed [RW-1:0]         rx_reg, rx_next;
    logic signed [RW-1:0]         rz_reg, rz_next;
    logic signed [31:0]           dx_reg, dx_next;
    logic signed [31:0]           dy_reg, dy_next;
    logic signed [31:0]           dz_reg, dz_next;
    logic [ANGLE_BITS-1:0]        dyaw_reg, dyaw_next;
    logic signed [POS_BITS-1:0]   acc_x_reg, acc_x_next;
    logic signed [POS_BITS-1:0]   acc_y_reg, acc_y_next;
    logic signed [POS_BITS-1:0]   acc_z_reg, acc_z_next;
    logic [ANGLE_BITS-1:0]        acc_h_reg, acc_h_next;
    logic signed [31:0]           pos_x_reg, pos_x_next;
    logic signed [31:0]           pos_y_reg, pos_y_next;
    logic signed [31:0]           pos_z_reg, pos_z_next;
    logic signed [15:0]           heading_reg, heading_next;
    logic                         saturated_reg, saturated_next;

    logic [ANGLE_BITS-1:0]        h_round;
    logic [1:0]                   quad;
    logic [ANGLE_BITS-1:0]        resid;
    logic signed [ZW-1:0]         z_init;
    logic signed [CW-1:0]         a_in, b_in, a_init, b_init;
    logic signed [CW-1:0]         sa, sb;
    logic signed [ZW-1:0]         step_atan;
    logic signed [CW-1:0]         mul_op;
    logic signed [PW-1:0]         prod_full;
    logic signed [PW-1:0]         rnd_sum;
    logic signed [EW-1:0]         dyaw_wide;
    logic signed [SW-1:0]         sum_x, sum_y, sum_z;
    logic signed [SW-1:0]         sat_x, sat_y, sat_z;
    logic                         ovf_x, ovf_y, ovf_z;
    logic [ANGLE_BITS-1:0]        h_new;
    logic [EW-1:0]                h_wide;

    function automatic logic signed [SW-1:0] clip(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        if (v > POS_MAX)
        begin
            r = POS_MAX;
        end
        else if (v < POS_MIN)
        begin
            r = POS_MIN;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // split heading into nearest quarter turn and residual
    always_comb
    begin
        h_round = acc_h_reg + EIGHTH;
        quad    = h_round[ANGLE_BITS-1 -: 2];
        resid   = acc_h_reg - {quad, {(ANGLE_BITS - 2){1'b0}}};
        z_init  = ZW'($signed(resid)) <<< ASH;
        a_in    = CW'(dz) <<< GUARD_SHIFT;
        b_in    = CW'(dx) <<< GUARD_SHIFT;
        case (quad)
            2'd0:
            begin
                a_init = a_in;
                b_init = b_in;
            end
            2'd1:
            begin
                a_init = -b_in;
                b_init = a_in;
            end
            2'd2:
            begin
                a_init = -a_in;
                b_init = -b_in;
            end
            default:
            begin
                a_init = b_in;
                b_init = -a_in;
            end
        endcase
    end

    always_comb
    begin
        sa        = a_reg >>> cmd.iter;
        sb        = b_reg >>> cmd.iter;
        step_atan = atan_entry(cmd.iter);
        mul_op    = cmd.mul_x ? b_reg : a_reg;
        prod_full = mul_op * GAIN;
        rnd_sum   = prod_reg + ROUND_C;
        dyaw_wide = EW'(dyaw);
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        z_next    = z_reg;
        dx_next   = dx_reg;
        dy_next   = dy_reg;
        dz_next   = dz_reg;
        dyaw_next = dyaw_reg;
        if (cmd.load)
        begin
            a_next    = a_init;
            b_next    = b_init;
            z_next    = z_init;
            dx_next   = dx;
            dy_next   = dy;
            dz_next   = dz;
            dyaw_next = dyaw_wide[ANGLE_BITS-1:0];
        end
        else if (cmd.rot)
        begin
            if (!z_reg[ZW-1])
            begin
                a_next = a_reg - sb;
                b_next = b_reg + sa;
                z_next = z_reg - step_atan;
            end
            else
            begin
                a_next = a_reg + sb;
                b_next = b_reg - sa;
                z_next = z_reg + step_atan;
            end
        end
    end

    always_comb
    begin
        prod_next = (cmd.mul_x || cmd.mul_z) ? prod_full : prod_reg;
        rx_next   = cmd.mul_z ? rnd_sum[OUT_SHIFT +: RW] : rx_reg;
        rz_next   = cmd.rnd ? rnd_sum[OUT_SHIFT +: RW] : rz_reg;
    end

    always_comb
    begin
        if (cmd.start_mode)
        begin
            sum_x = SW'(dx_reg);
            sum_y = SW'(dy_reg);
            sum_z = SW'(dz_reg);
            h_new = dyaw_reg;
        end
        else
        begin
            sum_x = SW'(acc_x_reg) + SW'(rx_reg);
            sum_y = SW'(acc_y_reg) + SW'(dy_reg);
            sum_z = SW'(acc_z_reg) + SW'(rz_reg);
            h_new = acc_h_reg + dyaw_reg;
        end
        sat_x  = clip(sum_x);
        sat_y  = clip(sum_y);
        sat_z  = clip(sum_z);
        ovf_x  = (sum_x > POS_MAX) || (sum_x < POS_MIN);
        ovf_y  = (sum_y > POS_MAX) || (sum_y < POS_MIN);
        ovf_z  = (sum_z > POS_MAX) || (sum_z < POS_MIN);
        h_wide = EW'(h_new);

        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        acc_z_next     = acc_z_reg;
        acc_h_next     = acc_h_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        pos_z_next     = pos_z_reg;
        heading_next   = heading_reg;
        saturated_next = saturated_reg;
        if (cmd.commit)
        begin
            acc_x_next     = sat_x[POS_BITS-1:0];
            acc_y_next     = sat_y[POS_BITS-1:0];
            acc_z_next     = sat_z[POS_BITS-1:0];
            acc_h_next     = h_new;
            pos_x_next     = sat_x[31:0];
            pos_y_next     = sat_y[31:0];
            pos_z_next     = sat_z[31:0];
            heading_next   = h_wide[15:0];
            saturated_next = ovf_x || ovf_y || ovf_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_z_reg <= '0;
            acc_h_reg <= '0;
        end
        else
        begin
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
            acc_z_reg <= acc_z_next;
            acc_h_reg <= acc_h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        z_reg         <= z_next;
        prod_reg      <= prod_next;
        rx_reg        <= rx_next;
        rz_reg        <= rz_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        dz_reg        <= dz_next;
        dyaw_reg      <= dyaw_next;
        pos_x_reg     <= pos_x_next;
        pos_y_reg     <= pos_y_next;
        pos_z_reg     <= pos_z_next;
        heading_reg   <= heading_next;
        saturated_reg <= saturated_next;
    end

    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign heading   = heading_reg;
    assign saturated = saturated_reg;

endmodule

`default_nettype wire
